@@ rtl/ibh_pkg.sv @@
// Shared types, codes and defaults of the indexed binary heap.
package ibh_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        MODE_INSERT  = 3'd0,
        MODE_EXTRACT = 3'd1,
        MODE_PEEK    = 3'd2,
        MODE_INC_KEY = 3'd3,
        MODE_DEC_KEY = 3'd4,
        MODE_GET_KEY = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_RD,
        S_TOP_RD,
        S_LAST_RD,
        S_POS_RD,
        S_KEY_RD,
        S_UP,
        S_UP_CMP,
        S_DOWN,
        S_DN_L,
        S_DN_R,
        S_DN_SW,
        S_PLACE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
        logic [7:0]  handle;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] out_value;
        logic [31:0] out_key;
        logic [7:0]  out_handle;
        logic        is_empty;
        logic [8:0]  fill_count;
    } t_rsp;

endpackage

@@ rtl/ibh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ibh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ibh_cmp.sv @@
// Shared key comparator that decides heap order.
module ibh_cmp #(
    parameter int KEY_BITS = 32
) (
    input  logic [KEY_BITS-1:0] i_a,
    input  logic [KEY_BITS-1:0] i_b,
    input  logic                i_max_order,
    output logic                o_above
);

    always_comb begin
        if (i_max_order) begin
            o_above = (i_a > i_b);
        end else begin
            o_above = (i_a < i_b);
        end
    end

endmodule

@@ rtl/ibh_seq.sv @@
// Sequencer that runs heap operations over the slot and position memories.
module ibh_seq
    import ibh_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int IW         = $clog2(CAPACITY),
    parameter int SW         = IW + KEY_BITS + VALUE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_req          i_req,
    input  logic          i_max_order,
    output logic          o_busy,
    output logic          o_done,
    output t_rsp          o_rsp,
    output logic          o_slot_we,
    output logic [IW-1:0] o_slot_waddr,
    output logic [SW-1:0] o_slot_wdata,
    output logic [IW-1:0] o_slot_raddr,
    input  logic [SW-1:0] i_slot_rdata,
    output logic          o_pos_we,
    output logic [IW-1:0] o_pos_waddr,
    output logic [IW-1:0] o_pos_wdata,
    output logic [IW-1:0] o_pos_raddr,
    input  logic [IW-1:0] i_pos_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;
    localparam int VO = KEY_BITS;
    localparam int HO = KEY_BITS + VALUE_BITS;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [2:0]            r_mode, n_mode;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [SW-1:0]         r_ent, n_ent;
    logic [SW-1:0]         r_tmp, n_tmp;
    logic [IW-1:0]         r_p, n_p;
    logic [IW-1:0]         r_bpos, n_bpos;
    logic                  r_bself, n_bself;
    t_status               r_status, n_status;
    logic [31:0]           r_oval, n_oval;
    logic [31:0]           r_okey, n_okey;
    logic [7:0]            r_ohnd, n_ohnd;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [IW-1:0]         rd_h;
    logic [KEY_BITS-1:0]   cmp_a, cmp_b;
    logic                  above;
    logic [IW-1:0]         parent;
    logic [XW-1:0]         l_x, r_x, cnt_x;
    logic                  go_up;
    logic                  hnd_ok;

    assign rd_key = i_slot_rdata[KEY_BITS-1:0];
    assign rd_val = i_slot_rdata[VO +: VALUE_BITS];
    assign rd_h   = i_slot_rdata[HO +: IW];
    assign parent = (r_p - IW'(1)) >> 1;
    assign l_x    = XW'({r_p, 1'b1});
    assign r_x    = l_x + XW'(1);
    assign cnt_x  = XW'(r_cnt);
    assign go_up  = ((r_mode == MODE_INC_KEY) == i_max_order);
    assign hnd_ok = (32'(i_req.handle) < 32'(CAPACITY));

    always_comb begin
        unique case (r_state)
            S_DN_L: begin
                cmp_a = rd_key;
                cmp_b = r_ent[KEY_BITS-1:0];
            end
            S_DN_R: begin
                cmp_a = rd_key;
                cmp_b = r_tmp[KEY_BITS-1:0];
            end
            default: begin
                cmp_a = r_ent[KEY_BITS-1:0];
                cmp_b = rd_key;
            end
        endcase
    end

    ibh_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
        .i_a         (cmp_a),
        .i_b         (cmp_b),
        .i_max_order (i_max_order),
        .o_above     (above)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_p == IW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.mode)
                        MODE_INSERT: begin
                            n_state = (r_cnt == CW'(CAPACITY)) ? S_DONE : S_INS_RD;
                        end
                        MODE_EXTRACT, MODE_PEEK: begin
                            n_state = (r_cnt == '0) ? S_DONE : S_TOP_RD;
                        end
                        MODE_INC_KEY, MODE_DEC_KEY, MODE_GET_KEY: begin
                            n_state = hnd_ok ? S_POS_RD : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD:  n_state = S_UP;
            S_TOP_RD:  n_state = (r_mode == MODE_PEEK) ? S_DONE : S_LAST_RD;
            S_LAST_RD: n_state = S_DOWN;
            S_POS_RD:  n_state = (CW'(i_pos_rdata) < r_cnt) ? S_KEY_RD : S_DONE;
            S_KEY_RD: begin
                if (r_mode == MODE_GET_KEY) begin
                    n_state = S_DONE;
                end else begin
                    n_state = go_up ? S_UP : S_DOWN;
                end
            end
            S_UP:      n_state = (r_p == '0) ? S_PLACE : S_UP_CMP;
            S_UP_CMP:  n_state = above ? S_UP : S_PLACE;
            S_DOWN:    n_state = (l_x < cnt_x) ? S_DN_L : S_PLACE;
            S_DN_L:    n_state = (r_x < cnt_x) ? S_DN_R : S_DN_SW;
            S_DN_R:    n_state = S_DN_SW;
            S_DN_SW:   n_state = r_bself ? S_PLACE : S_DOWN;
            S_PLACE:   n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt        = r_cnt;
        n_mode       = r_mode;
        n_key        = r_key;
        n_value      = r_value;
        n_ent        = r_ent;
        n_tmp        = r_tmp;
        n_p          = r_p;
        n_bpos       = r_bpos;
        n_bself      = r_bself;
        n_status     = r_status;
        n_oval       = r_oval;
        n_okey       = r_okey;
        n_ohnd       = r_ohnd;
        o_slot_we    = 1'b0;
        o_slot_waddr = r_p;
        o_slot_wdata = r_ent;
        o_slot_raddr = '0;
        o_pos_we     = 1'b0;
        o_pos_waddr  = r_ent[HO +: IW];
        o_pos_wdata  = r_p;
        o_pos_raddr  = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_slot_we    = 1'b1;
                o_slot_wdata = {r_p, {(KEY_BITS + VALUE_BITS){1'b0}}};
                o_pos_we     = 1'b1;
                o_pos_waddr  = r_p;
                n_p          = r_p + IW'(1);
            end
            S_IDLE: begin
                if (i_start) begin
                    n_mode   = i_req.mode;
                    n_key    = KEY_BITS'(i_req.key);
                    n_value  = VALUE_BITS'(i_req.value);
                    n_status = ST_OK;
                    n_oval   = '0;
                    n_okey   = '0;
                    n_ohnd   = '0;
                    unique case (i_req.mode)
                        MODE_INSERT: begin
                            o_slot_raddr = IW'(r_cnt);
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end
                        end
                        MODE_EXTRACT, MODE_PEEK: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        MODE_INC_KEY, MODE_DEC_KEY, MODE_GET_KEY: begin
                            o_pos_raddr = IW'(i_req.handle);
                            if (!hnd_ok) begin
                                n_status = ST_ABSENT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                n_ent  = {rd_h, r_value, r_key};
                n_ohnd = 8'(rd_h);
                n_p    = IW'(r_cnt);
                n_cnt  = r_cnt + CW'(1);
            end
            S_TOP_RD: begin
                n_oval = 32'(rd_val);
                n_tmp  = i_slot_rdata;
                if (r_mode == MODE_EXTRACT) begin
                    n_cnt        = r_cnt - CW'(1);
                    o_slot_raddr = IW'(r_cnt - CW'(1));
                end
            end
            S_LAST_RD: begin
                n_ent        = i_slot_rdata;
                o_slot_we    = 1'b1;
                o_slot_waddr = IW'(r_cnt);
                o_slot_wdata = r_tmp;
                o_pos_we     = 1'b1;
                o_pos_waddr  = r_tmp[HO +: IW];
                o_pos_wdata  = IW'(r_cnt);
                n_p          = '0;
            end
            S_POS_RD: begin
                n_p          = i_pos_rdata;
                o_slot_raddr = i_pos_rdata;
                if (!(CW'(i_pos_rdata) < r_cnt)) begin
                    n_status = ST_ABSENT;
                end
            end
            S_KEY_RD: begin
                if (r_mode == MODE_GET_KEY) begin
                    n_okey = 32'(rd_key);
                end else begin
                    n_ent = {rd_h, rd_val, r_key};
                end
            end
            S_UP: begin
                o_slot_raddr = parent;
            end
            S_UP_CMP: begin
                if (above) begin
                    o_slot_we    = 1'b1;
                    o_slot_wdata = i_slot_rdata;
                    o_pos_we     = 1'b1;
                    o_pos_waddr  = rd_h;
                    n_p          = parent;
                end
            end
            S_DOWN: begin
                o_slot_raddr = IW'(l_x);
            end
            S_DN_L: begin
                o_slot_raddr = IW'(r_x);
                if (above) begin
                    n_tmp   = i_slot_rdata;
                    n_bpos  = IW'(l_x);
                    n_bself = 1'b0;
                end else begin
                    n_tmp   = r_ent;
                    n_bpos  = r_p;
                    n_bself = 1'b1;
                end
            end
            S_DN_R: begin
                if (above) begin
                    n_tmp   = i_slot_rdata;
                    n_bpos  = IW'(r_x);
                    n_bself = 1'b0;
                end
            end
            S_DN_SW: begin
                if (!r_bself) begin
                    o_slot_we    = 1'b1;
                    o_slot_wdata = r_tmp;
                    o_pos_we     = 1'b1;
                    o_pos_waddr  = r_tmp[HO +: IW];
                    n_p          = r_bpos;
                end
            end
            S_PLACE: begin
                o_slot_we = 1'b1;
                o_pos_we  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_busy              = (r_state != S_IDLE);
        o_done              = (r_state == S_DONE);
        o_rsp.status        = r_status;
        o_rsp.out_value     = r_oval;
        o_rsp.out_key       = r_okey;
        o_rsp.out_handle    = r_ohnd;
        o_rsp.is_empty      = (r_cnt == '0);
        o_rsp.fill_count    = 9'(r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_p     <= n_p;
        end
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_value  <= n_value;
        r_ent    <= n_ent;
        r_tmp    <= n_tmp;
        r_bpos   <= n_bpos;
        r_bself  <= n_bself;
        r_status <= n_status;
        r_oval   <= n_oval;
        r_okey   <= n_okey;
        r_ohnd   <= n_ohnd;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted request did not make the block busy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_status == ST_FULL) |-> (r_cnt == CW'(CAPACITY)))
        else $error("full status reported below capacity");

endmodule

@@ rtl/indexed_binary_heap_top.sv @@
// Top level of the indexed binary heap priority queue.
//
// A request is taken when start is high and busy is low; it carries mode,
// key, value and handle. Modes are insert, extract, peek, increase key,
// decrease key and get key. Exactly one result follows per request: o_done
// is high for one cycle with o_rsp valid, and the receiver cannot stall it.
// Busy stays high from acceptance until the cycle after o_done.
// A rejected request or an unused mode goes straight to its result; peek reads
// the top slot, get key the position table and then the slot. An element that
// moves walks upward through a parent read and a compare per level, or downward
// through a left-child read, a left and a right compare (none on the right where
// that child is missing) and a swap per level, via the single slot memory read
// port; the next request can be taken in the cycle after the result.
// The cfg channel writes the ordering bit (1 keeps the largest key on top)
// and is always ready; write it only while the block is idle.
// After reset the block fills all CAPACITY entries (256 by default) of the slot and
// position tables with their initial handles, busy all along.
module indexed_binary_heap_top
    import ibh_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp,
    input  logic i_cfg_valid,
    input  logic i_cfg_data,
    output logic o_cfg_ready
);

    localparam int IW = $clog2(CAPACITY);
    localparam int SW = IW + KEY_BITS + VALUE_BITS;

    logic          r_max_order;
    logic          slot_we;
    logic [IW-1:0] slot_waddr;
    logic [SW-1:0] slot_wdata;
    logic [IW-1:0] slot_raddr;
    logic [SW-1:0] slot_rdata;
    logic          pos_we;
    logic [IW-1:0] pos_waddr;
    logic [IW-1:0] pos_wdata;
    logic [IW-1:0] pos_raddr;
    logic [IW-1:0] pos_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_order <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_order <= i_cfg_data;
        end
    end

    ibh_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ibh_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    ibh_seq #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IW         (IW),
        .SW         (SW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_req),
        .i_max_order  (r_max_order),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_rsp        (o_rsp),
        .o_slot_we    (slot_we),
        .o_slot_waddr (slot_waddr),
        .o_slot_wdata (slot_wdata),
        .o_slot_raddr (slot_raddr),
        .i_slot_rdata (slot_rdata),
        .o_pos_we     (pos_we),
        .o_pos_waddr  (pos_waddr),
        .o_pos_wdata  (pos_wdata),
        .o_pos_raddr  (pos_raddr),
        .i_pos_rdata  (pos_rdata)
    );

endmodule

@@ dv/indexed_binary_heap_top_tb.sv @@
// Self-checking testbench of the indexed binary heap priority queue.
`timescale 1ns / 1ps

module indexed_binary_heap_top_tb
    import ibh_pkg::*;
();

    localparam int CAP = 256;
    localparam int WATCHDOG_LIMIT = 4000;

    class heap_scoreboard;
        logic [31:0] hkey [CAP];
        logic [31:0] hval [CAP];
        logic [7:0]  slot_hdl [CAP];
        logic [7:0]  hdl_pos [CAP];
        int          count;
        bit          max_first;
        t_rsp        pending [$];
        int          errors;

        function void clear();
            for (int i = 0; i < CAP; i++) begin
                hkey[i] = '0;
                hval[i] = '0;
                slot_hdl[i] = i[7:0];
                hdl_pos[i] = i[7:0];
            end
            count = 0;
            max_first = 0;
            errors = 0;
        endfunction

        function bit ranks_above(logic [31:0] a, logic [31:0] b);
            return max_first ? (a > b) : (a < b);
        endfunction

        function void swap_slots(int a, int b);
            logic [31:0] tk;
            logic [31:0] tv;
            logic [7:0]  ha;
            logic [7:0]  hb;
            tk = hkey[a];
            tv = hval[a];
            ha = slot_hdl[a];
            hb = slot_hdl[b];
            hkey[a] = hkey[b];
            hkey[b] = tk;
            hval[a] = hval[b];
            hval[b] = tv;
            slot_hdl[a] = hb;
            slot_hdl[b] = ha;
            hdl_pos[ha] = b[7:0];
            hdl_pos[hb] = a[7:0];
        endfunction

        function void sift_up(int pos);
            int parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!ranks_above(hkey[pos], hkey[parent])) break;
                swap_slots(pos, parent);
                pos = parent;
            end
        endfunction

        function void sift_down(int pos);
            int l;
            int r;
            int best;
            forever begin
                l = 2 * pos + 1;
                r = 2 * pos + 2;
                best = pos;
                if (l < count && ranks_above(hkey[l], hkey[best])) best = l;
                if (r < count && ranks_above(hkey[r], hkey[best])) best = r;
                if (best == pos) break;
                swap_slots(pos, best);
                pos = best;
            end
        endfunction

        function void note_request(t_req rq);
            t_rsp rs;
            int   pos;
            rs = '0;
            rs.status = ST_OK;
            case (rq.mode)
                MODE_INSERT: begin
                    if (count >= CAP) begin
                        rs.status = ST_FULL;
                    end else begin
                        pos = count;
                        rs.out_handle = slot_hdl[pos];
                        hkey[pos] = rq.key;
                        hval[pos] = rq.value;
                        sift_up(pos);
                        count++;
                    end
                end
                MODE_EXTRACT, MODE_PEEK: begin
                    if (count == 0) begin
                        rs.status = ST_EMPTY;
                    end else begin
                        rs.out_value = hval[0];
                        if (rq.mode == MODE_EXTRACT) begin
                            count--;
                            swap_slots(0, count);
                            sift_down(0);
                        end
                    end
                end
                MODE_INC_KEY, MODE_DEC_KEY, MODE_GET_KEY: begin
                    pos = hdl_pos[rq.handle];
                    if (pos >= count) begin
                        rs.status = ST_ABSENT;
                    end else if (rq.mode == MODE_GET_KEY) begin
                        rs.out_key = hkey[pos];
                    end else begin
                        hkey[pos] = rq.key;
                        if ((rq.mode == MODE_INC_KEY) == max_first) sift_up(pos);
                        else sift_down(pos);
                    end
                end
                default: ;
            endcase
            rs.is_empty = (count == 0);
            rs.fill_count = count[8:0];
            pending.push_back(rs);
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.out_value !== exp.out_value) begin
                $display("%0t: out_value exp %h got %h", $time, exp.out_value, got.out_value);
                errors++;
            end
            if (got.out_key !== exp.out_key) begin
                $display("%0t: out_key exp %h got %h", $time, exp.out_key, got.out_key);
                errors++;
            end
            if (got.out_handle !== exp.out_handle) begin
                $display("%0t: out_handle exp %h got %h", $time, exp.out_handle,
                         got.out_handle);
                errors++;
            end
            if (got.is_empty !== exp.is_empty) begin
                $display("%0t: is_empty exp %b got %b", $time, exp.is_empty, got.is_empty);
                errors++;
            end
            if (got.fill_count !== exp.fill_count) begin
                $display("%0t: fill_count exp %0d got %0d", $time, exp.fill_count,
                         got.fill_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;
    logic i_cfg_valid;
    logic i_cfg_data;
    logic o_cfg_ready;

    heap_scoreboard board;
    int gap_pct;
    int idle_cycles;

    indexed_binary_heap_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_done(o_done), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data), .o_cfg_ready(o_cfg_ready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_request(i_req);
            if (o_done) board.check_result(o_rsp);
            if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic issue(logic [2:0] m, logic [31:0] k, logic [31:0] v, logic [7:0] h);
        while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        start <= 1'b1;
        i_req <= '{mode: m, key: k, value: v, handle: h};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_order(logic max_first);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= max_first;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board.max_first = max_first;
    endtask

    task automatic random_phase(int n, int pct);
        int          r;
        logic [31:0] k;
        logic [7:0]  h;
        gap_pct = pct;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            k = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom;
            h = 8'($urandom_range(255));
            if (r < 35) issue(MODE_INSERT, k, $urandom, h);
            else if (r < 55) issue(MODE_EXTRACT, $urandom, $urandom, h);
            else if (r < 62) issue(MODE_PEEK, $urandom, $urandom, h);
            else if (r < 75) issue(MODE_INC_KEY, k, $urandom, h);
            else if (r < 88) issue(MODE_DEC_KEY, k, $urandom, h);
            else if (r < 97) issue(MODE_GET_KEY, $urandom, $urandom, h);
            else issue(3'($urandom_range(7)), $urandom, $urandom, h);
        end
    endtask

    initial begin
        board = new();
        board.clear();
        idle_cycles = 0;
        gap_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_order(1'b0);
        issue(MODE_EXTRACT, 0, 0, 0);
        issue(MODE_PEEK, 0, 0, 0);
        issue(MODE_GET_KEY, 0, 0, 8'd0);
        issue(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        issue(MODE_INSERT, 32'h0, 32'h0, 8'h00);
        issue(MODE_INSERT, 32'h5, 32'h1234_5678, 8'h00);
        issue(MODE_INSERT, 32'h5, 32'h8765_4321, 8'h00);
        issue(MODE_PEEK, 0, 0, 0);
        issue(MODE_GET_KEY, 0, 0, 8'd0);
        issue(MODE_GET_KEY, 0, 0, 8'd200);
        issue(MODE_INC_KEY, 32'hFFFF_FFFE, 0, 8'd1);
        issue(MODE_DEC_KEY, 32'd1, 0, 8'd0);
        issue(MODE_INC_KEY, 32'd0, 0, 8'd0);
        issue(MODE_DEC_KEY, 32'hFFFF_FFFF, 0, 8'd2);
        issue(MODE_INC_KEY, 32'd3, 0, 8'd255);
        issue(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        issue(3'd7, 0, 0, 0);
        issue(MODE_EXTRACT, 0, 0, 0);
        issue(MODE_EXTRACT, 0, 0, 0);

        write_order(1'b1);
        gap_pct = 28;
        for (int i = 0; i < 258; i++) issue(MODE_INSERT, $urandom_range(40), $urandom, 0);
        issue(MODE_GET_KEY, 0, 0, 8'd255);
        random_phase(200, 28);
        write_order(1'b0);
        random_phase(200, 28);
        for (int i = 0; i < 260; i++) issue(MODE_EXTRACT, 0, 0, 0);
        random_phase(150, 56);
        write_order(1'b1);
        random_phase(150, 56);
        write_order(1'b0);
        random_phase(150, 0);

        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/ibh_pkg.sv
rtl/ibh_ram.sv
rtl/ibh_cmp.sv
rtl/ibh_seq.sv
rtl/indexed_binary_heap_top.sv
dv/indexed_binary_heap_top_tb.sv
